### hdl/qebe_pkg.sv
// Shared types and constants for the quadrature encoder and button event unit.
package qebe_pkg;

    localparam int POS_W   = 16;
    localparam int EV_W    = 3;
    localparam int TICK_W  = 16;
    localparam int DEB_W   = 8;
    localparam int CLICK_W = 2;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    localparam logic [TICK_W-1:0]  TICK_MAX  = '1;
    localparam logic [DEB_W-1:0]   DEB_MAX   = '1;
    localparam logic [CLICK_W-1:0] CLICK_MAX = '1;

    // register reset values
    localparam logic              RST_DECODER_MODE = 1'b0;
    localparam logic              RST_ACTIVE_LEVEL = 1'b0;
    localparam logic [DEB_W-1:0]  RST_DEBOUNCE     = 8'd3;
    localparam logic [TICK_W-1:0] RST_SHORT        = 16'd30;
    localparam logic [TICK_W-1:0] RST_LONG_PRESS   = 16'd100;
    localparam logic [TICK_W-1:0] RST_HOLD         = 16'd200;

    // table decoder: history codes that count
    localparam logic [3:0] HIST_DOWN = 4'h2;
    localparam logic [3:0] HIST_UP   = 4'h8;

    typedef enum logic [EV_W-1:0] {
        EV_PRESSED       = 3'd0,
        EV_LONG          = 3'd1,
        EV_HOLD          = 3'd2,
        EV_RELEASED      = 3'd3,
        EV_LONG_RELEASED = 3'd4,
        EV_CLICK         = 3'd5,
        EV_DOUBLE        = 3'd6,
        EV_NONE          = 3'd7
    } t_event;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_DOWN  = 3'd1,
        PH_GAP   = 3'd2,
        PH_AGAIN = 3'd3,
        PH_LONG  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        REG_DECODER_MODE = 3'd0,
        REG_ACTIVE_LEVEL = 3'd1,
        REG_DEBOUNCE     = 3'd2,
        REG_SHORT        = 3'd3,
        REG_LONG_PRESS   = 3'd4,
        REG_HOLD         = 3'd5
    } t_reg_idx;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef struct packed {
        logic              decoder_mode;
        logic              active_level;
        logic [DEB_W-1:0]  deb_limit;
        logic [TICK_W-1:0] gap_limit;
        logic [TICK_W-1:0] long_limit;
        logic [TICK_W-1:0] hold_ticks;
    } t_cfg;

    typedef struct packed {
        logic   valid;
        t_event code;
    } t_btn_put;

endpackage

### hdl/qebe_in_if.sv
// Request channel: tick or pop with raw pin levels.
interface qebe_in_if;
    logic valid;
    logic ready;
    logic operation;
    logic pin_a;
    logic pin_b;
    logic pin_switch;

    modport source (output valid, output operation, output pin_a, output pin_b,
                    output pin_switch, input ready);
    modport sink   (input valid, input operation, input pin_a, input pin_b,
                    input pin_switch, output ready);
endinterface

### hdl/qebe_out_if.sv
// Result channel: position and popped event.
interface qebe_out_if import qebe_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  position;
    logic        [EV_W-1:0]   event_code;

    modport source (output valid, output position, output event_code, input ready);
    modport sink   (input valid, input position, input event_code, output ready);
endinterface

### hdl/qebe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qebe_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/qebe_regs.sv
// APB configuration register bank.
module qebe_regs import qebe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    logic     w_wr;
    t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decoder_mode <= RST_DECODER_MODE;
            r_cfg.active_level <= RST_ACTIVE_LEVEL;
            r_cfg.deb_limit    <= RST_DEBOUNCE;
            r_cfg.gap_limit    <= RST_SHORT;
            r_cfg.long_limit   <= RST_LONG_PRESS;
            r_cfg.hold_ticks   <= RST_HOLD;
        end else if (w_wr) begin
            case (w_idx)
                REG_DECODER_MODE: r_cfg.decoder_mode <= pwdata[0];
                REG_ACTIVE_LEVEL: r_cfg.active_level <= pwdata[0];
                REG_DEBOUNCE:     r_cfg.deb_limit    <= pwdata[DEB_W-1:0];
                REG_SHORT:        r_cfg.gap_limit    <= pwdata[TICK_W-1:0];
                REG_LONG_PRESS:   r_cfg.long_limit   <= pwdata[TICK_W-1:0];
                REG_HOLD:         r_cfg.hold_ticks   <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_DECODER_MODE: prdata = APB_DW'(r_cfg.decoder_mode);
            REG_ACTIVE_LEVEL: prdata = APB_DW'(r_cfg.active_level);
            REG_DEBOUNCE:     prdata = APB_DW'(r_cfg.deb_limit);
            REG_SHORT:        prdata = APB_DW'(r_cfg.gap_limit);
            REG_LONG_PRESS:   prdata = APB_DW'(r_cfg.long_limit);
            REG_HOLD:         prdata = APB_DW'(r_cfg.hold_ticks);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/qebe_decoder.sv
// Quadrature decoder: Gray-difference or transition-table mode, wrapping position.
module qebe_decoder import qebe_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic                    i_mode,
    input  logic                    i_a_act,
    input  logic                    i_b_act,
    output logic signed [POS_W-1:0] o_position,
    output logic signed [POS_W-1:0] o_position_next
);

    logic        [3:0]       r_hist, n_hist;
    logic signed [POS_W-1:0] r_pos, n_pos;
    logic        [1:0]       w_cur;
    logic        [1:0]       w_diff;
    logic        [3:0]       w_shift;

    assign w_cur   = {i_a_act, i_a_act ^ i_b_act};
    assign w_diff  = r_hist[1:0] - w_cur;
    assign w_shift = {r_hist[1:0], i_a_act, i_b_act};

    always_comb begin
        n_hist = r_hist;
        n_pos  = r_pos;
        if (!i_mode) begin
            if (w_diff[0]) begin
                n_hist = {2'b00, w_cur};
                n_pos  = w_diff[1] ? r_pos + 16'sd1 : r_pos - 16'sd1;
            end
        end else begin
            n_hist = w_shift;
            if (w_shift == HIST_DOWN) begin
                n_pos = r_pos - 16'sd1;
            end else if (w_shift == HIST_UP) begin
                n_pos = r_pos + 16'sd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_pos  <= '0;
        end else if (i_step) begin
            r_hist <= n_hist;
            r_pos  <= n_pos;
        end
    end

    assign o_position      = r_pos;
    assign o_position_next = n_pos;

endmodule

### hdl/qebe_button.sv
// Switch debounce and button event state machine.
module qebe_button import qebe_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  logic     i_sw_act,
    input  t_cfg     i_cfg,
    output t_btn_put o_put
);

    logic [DEB_W-1:0]   r_deb_cnt, n_deb_cnt, w_deb_inc;
    logic               r_level, n_level;
    t_phase             r_phase, n_phase;
    logic [TICK_W-1:0]  r_ticks, n_ticks, w_ticks;
    logic [CLICK_W-1:0] r_clicks, n_clicks;
    t_event             r_event, n_event;
    logic               w_report;

    // tick counter advances first, saturating
    assign w_ticks = (r_phase != PH_IDLE && r_ticks != TICK_MAX) ? r_ticks + 16'd1
                                                                 : r_ticks;

    // debounce
    assign w_deb_inc = (r_deb_cnt == DEB_MAX) ? r_deb_cnt : r_deb_cnt + 8'd1;

    always_comb begin
        n_level   = r_level;
        n_deb_cnt = '0;
        if (i_sw_act != r_level) begin
            n_deb_cnt = w_deb_inc;
            if (w_deb_inc >= i_cfg.deb_limit) begin
                n_level   = i_sw_act;
                n_deb_cnt = '0;
            end
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE: begin
                if (n_level) n_phase = PH_DOWN;
            end
            PH_DOWN: begin
                if (!n_level) n_phase = PH_GAP;
                else if (w_ticks > i_cfg.long_limit) n_phase = PH_LONG;
            end
            PH_GAP: begin
                if (n_level) n_phase = PH_AGAIN;
                else if (w_ticks > i_cfg.gap_limit) n_phase = PH_IDLE;
            end
            PH_AGAIN: begin
                if (!n_level) n_phase = (w_ticks < i_cfg.gap_limit) ? PH_GAP : PH_IDLE;
            end
            PH_LONG: begin
                if (!n_level) n_phase = PH_IDLE;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // phase outputs: counters, event, report
    always_comb begin
        n_ticks  = w_ticks;
        n_clicks = r_clicks;
        n_event  = r_event;
        w_report = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (n_level) begin
                    n_ticks  = '0;
                    n_event  = EV_PRESSED;
                    w_report = 1'b1;
                end else begin
                    n_event = EV_NONE;
                end
            end
            PH_DOWN: begin
                if (!n_level) begin
                    n_clicks = CLICK_W'(1);
                    n_ticks  = '0;
                end else if (w_ticks > i_cfg.long_limit) begin
                    n_event  = EV_LONG;
                    w_report = 1'b1;
                end
            end
            PH_GAP: begin
                if (n_level) begin
                    n_ticks = '0;
                end else if (w_ticks > i_cfg.gap_limit) begin
                    if (r_clicks == CLICK_W'(1)) n_event = EV_CLICK;
                    else if (r_clicks == CLICK_W'(2)) n_event = EV_DOUBLE;
                    w_report = 1'b1;
                end
            end
            PH_AGAIN: begin
                if (!n_level && w_ticks < i_cfg.gap_limit) begin
                    if (r_clicks != CLICK_MAX) n_clicks = r_clicks + CLICK_W'(1);
                    n_ticks  = '0;
                    n_event  = EV_RELEASED;
                    w_report = 1'b1;
                end
            end
            PH_LONG: begin
                if (n_level) begin
                    n_event  = (w_ticks > i_cfg.hold_ticks) ? EV_HOLD : EV_LONG;
                    w_report = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb_cnt <= '0;
            r_level   <= 1'b0;
            r_phase   <= PH_IDLE;
            r_ticks   <= '0;
            r_clicks  <= '0;
            r_event   <= EV_NONE;
        end else if (i_step) begin
            r_deb_cnt <= n_deb_cnt;
            r_level   <= n_level;
            r_phase   <= n_phase;
            r_ticks   <= n_ticks;
            r_clicks  <= n_clicks;
            r_event   <= n_event;
        end
    end

    assign o_put.valid = i_step & w_report;
    assign o_put.code  = n_event;

endmodule

### hdl/quadrature_encoder_button_events_unit.sv
// Top level: quadrature encoder with button event detection and event queue.
//
//  channel   | dir | handshake           | payload
//  ----------+-----+---------------------+-----------------------------------------
//  i_req     | in  | valid / ready       | operation, pin_a, pin_b, pin_switch
//  o_rsp     | out | valid / ready       | position (s16), event_code (3b)
//  APB       | in  | psel/penable/pready | paddr (5b), pwdata/prdata (32b)
//
//  One request per cycle sustained while o_rsp.ready holds high. A request is
//  captured into an input stage, processed in one pass and lands in the result
//  register, which drives o_rsp.valid. Pops read the event RAM, whose registered
//  read data forms part of the result register.
//  Synchronous active-low reset clears all control state; the event store
//  needs no clearing pass since only written entries are ever popped.
//  A stalled result holds the input stage; i_req.ready drops only when both
//  the input stage and the result register are full and o_rsp.ready is low.
module quadrature_encoder_button_events_unit import qebe_pkg::*; #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    qebe_in_if.sink           i_req,
    qebe_out_if.source        o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int                PTR_W    = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    t_cfg w_cfg;

    // input stage
    logic r_in_valid;
    t_op  r_in_op;
    logic r_in_a, r_in_b, r_in_sw;

    // result register
    logic                    r_out_valid;
    logic signed [POS_W-1:0] r_out_pos;
    logic                    r_out_has_ev;

    // queue pointers
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] w_rd_inc, w_wr_inc;

    logic                    w_advance;
    logic                    w_tick, w_pop;
    logic                    w_a_act, w_b_act, w_sw_act;
    logic                    w_empty, w_full;
    logic                    w_wr_en, w_rd_en;
    logic signed [POS_W-1:0] w_pos, w_pos_next;
    logic [EV_W-1:0]         w_rd_data;
    t_btn_put                w_put;

    qebe_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // the processed item moves into the result register when that slot is free
    assign w_advance   = r_in_valid & (~r_out_valid | o_rsp.ready);
    assign i_req.ready = ~r_in_valid | w_advance;
    assign w_tick      = w_advance & (r_in_op == OP_TICK);
    assign w_pop       = w_advance & (r_in_op == OP_POP);

    // pins compared against the active level
    assign w_a_act  = ~(r_in_a  ^ w_cfg.active_level);
    assign w_b_act  = ~(r_in_b  ^ w_cfg.active_level);
    assign w_sw_act = ~(r_in_sw ^ w_cfg.active_level);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_op <= t_op'(i_req.operation);
            r_in_a  <= i_req.pin_a;
            r_in_b  <= i_req.pin_b;
            r_in_sw <= i_req.pin_switch;
        end
    end

    qebe_decoder u_decoder (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_tick),
        .i_mode          (w_cfg.decoder_mode),
        .i_a_act         (w_a_act),
        .i_b_act         (w_b_act),
        .o_position      (w_pos),
        .o_position_next (w_pos_next)
    );

    qebe_button u_button (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_tick),
        .i_sw_act (w_sw_act),
        .i_cfg    (w_cfg),
        .o_put    (w_put)
    );

    // ring queue: holds up to QUEUE_DEPTH-1 events, drops new ones when full
    assign w_rd_inc = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
    assign w_wr_inc = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
    assign w_empty  = (r_rd_ptr == r_wr_ptr);
    assign w_full   = (w_wr_inc == r_rd_ptr);
    assign w_wr_en  = w_put.valid & ~w_full;
    assign w_rd_en  = w_pop & ~w_empty;
    assign n_wr_ptr = w_wr_en ? w_wr_inc : r_wr_ptr;
    assign n_rd_ptr = w_rd_en ? w_rd_inc : r_rd_ptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
        end
    end

    qebe_ram #(
        .WIDTH (EV_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_event_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (w_put.code),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (w_rd_data)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_out_has_ev <= 1'b0;
        end else if (w_advance) begin
            r_out_valid  <= 1'b1;
            r_out_has_ev <= w_rd_en;
        end else if (o_rsp.ready) begin
            r_out_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_pos <= w_tick ? w_pos_next : w_pos;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.position   = r_out_pos;
    assign o_rsp.event_code = r_out_has_ev ? w_rd_data : EV_NONE;

    // a waiting request in the input stage is never lost
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid)
        else $error("input stage dropped a waiting request");

    // ticks never move the read pointer
    a_tick_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick |=> $stable(r_rd_ptr))
        else $error("tick changed the queue read pointer");

    // pops never move the position or the write pointer
    a_pop_no_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> $stable(w_pos) && $stable(r_wr_ptr))
        else $error("pop changed position or queue write pointer");

    // an event result comes only from a non-empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && w_empty |=> !r_out_has_ev && $stable(r_rd_ptr))
        else $error("pop on empty queue returned an event");

endmodule
